FILE: rtl/square_path_go_to_goal_controller_defines.svh
// Assertion helpers shared by the controller RTL.
`ifndef SQUARE_PATH_GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`define SQUARE_PATH_GO_TO_GOAL_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQG2G_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SQG2G_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sqg2g_pkg.sv
package sqg2g_pkg;

    // Default iteration count of the vectoring unit
    localparam int CORDIC_STEPS_DEF = 16;

    // Field widths
    localparam int POS_W      = 24;
    localparam int HEAD_W     = 19;
    localparam int SIDE_W     = 23;
    localparam int GAIN_W     = 16;
    localparam int LIN_W      = 24;
    localparam int ANGV_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Internal widths
    localparam int DELTA_W    = 26;   // corner minus pose
    localparam int GUARD_BITS = 8;
    localparam int VEC_W      = 36;   // CORDIC x/y, signed
    localparam int XU_W       = VEC_W - 1;
    localparam int ANG_W      = 21;   // CORDIC z, signed Q4.16
    localparam int ATAN_W     = 16;
    localparam int ERR_W      = 22;   // heading error, signed
    localparam int MAG_W      = 27;   // distance, unsigned Q11.16
    localparam int MUL_A_W    = 16;
    localparam int MUL_B_W    = 28;
    localparam int PROD_W     = 44;
    localparam int ACC_W      = 52;
    localparam int XL_W       = 18;   // low slice of x for the magnitude scale
    localparam int XH_W       = XU_W - XL_W;
    localparam int MAG_SH     = 24;
    localparam int GAIN_SH    = 8;

    // Constants
    localparam int PI_Q      = 205887;
    localparam int TWO_PI_Q  = 411774;
    localparam int INV_K_Q16 = 39797;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_SIDE_LENGTH = 3'd2,
        CFG_ARRIVE_TOL  = 3'd3,
        CFG_LIN_GAIN    = 3'd4,
        CFG_ANG_GAIN    = 3'd5
    } t_cfg_idx;

    // CORDIC control and status
    typedef struct packed {
        logic load;
    } t_cordic_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

    // Shared multiplier request
    typedef struct packed {
        logic                      issue;
        logic [MUL_A_W-1:0]        a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    // round(atan(2^-i) * 2^16)
    function automatic logic [ATAN_W-1:0] atan_q(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/sqg2g_cordic.sv
module sqg2g_cordic
    import sqg2g_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cordic_ctl               i_ctl,
    input  logic signed [DELTA_W-1:0] i_dx,
    input  logic signed [DELTA_W-1:0] i_dy,
    output t_cordic_sts               o_sts,
    output logic [XU_W-1:0]           o_x,
    output logic signed [ANG_W-1:0]   o_z
);

    localparam int IW = $clog2(STEPS);
    localparam logic [IW-1:0] LAST_I = IW'(STEPS - 1);
    localparam logic signed [ANG_W-1:0] C_PI = ANG_W'(PI_Q);

    logic signed [VEC_W-1:0] r_x;
    logic signed [VEC_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [IW-1:0]           r_i;
    logic                    r_busy;
    logic                    r_done;
    logic                    r_zero;

    logic signed [VEC_W-1:0] w_x0;
    logic signed [VEC_W-1:0] w_y0;
    logic signed [VEC_W-1:0] w_xs;
    logic signed [VEC_W-1:0] w_ys;
    logic signed [ANG_W-1:0] w_atan;
    logic                    w_zero;

    // Scale the deltas by the guard bits
    assign w_x0 = {{(VEC_W-DELTA_W-GUARD_BITS){i_dx[DELTA_W-1]}}, i_dx, {GUARD_BITS{1'b0}}};
    assign w_y0 = {{(VEC_W-DELTA_W-GUARD_BITS){i_dy[DELTA_W-1]}}, i_dy, {GUARD_BITS{1'b0}}};
    assign w_zero = (i_dx == '0) && (i_dy == '0);

    // Shared shift and table lookup for the current micro-rotation
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = ANG_W'(atan_q(5'(r_i)));

    // Control: load, iterate, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_ctl.load) begin
            r_busy <= !w_zero;
            r_done <= w_zero;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == LAST_I) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: pre-rotate left-half vectors, then one rotation per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_zero <= w_zero;
            if (i_dx < 0) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= (i_dy >= 0) ? C_PI : -C_PI;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_x = r_x[VEC_W-1] ? '0 : r_x[XU_W-1:0];
    assign o_z = r_zero ? '0 : r_z;

endmodule

FILE: rtl/sqg2g_mul.sv
module sqg2g_mul
    import sqg2g_pkg::*;
(
    input  logic                     i_clk,
    input  t_mul_req                 i_req,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MUL_B_W+MUL_A_W:0] w_full;

    // Unsigned gain or constant times signed operand
    assign w_full = $signed({1'b0, i_req.a}) * i_req.b;

    // Hold the product until the next request
    always_ff @(posedge i_clk) begin
        if (i_req.issue) begin
            r_prod <= w_full[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/square_path_go_to_goal_controller.sv
// Proportional go-to-goal controller that walks the corners of a square.
// Input channel (i_in_valid / o_in_ready): one pose request (x, y, heading).
// Output channel (o_out_valid / i_out_ready): one command per pose with
// linear and angular velocity, the corner now targeted and a reached flag.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): register index
// and data; write only while no pose is in flight. Unknown indexes are dropped.
// Each pose runs one CORDIC vectoring pass plus a shared 16x28 multiplier
// for the distance scale and both gains, and one extra pass when the corner
// is reached and the goal advances; the heading error is wrapped into
// (-pi, pi] before the angular gain is applied. A pass whose vector is zero
// skips its rotations.
// The next pose is accepted the cycle
// after the result is loaded; the output register lets it enter while the
// previous command still waits. If the receiver stalls with a command held,
// the next pose is computed and then waits until the held one is taken.
// Synchronous active-low reset restores default gains, side and tolerance,
// zero origin, targets the first corner and empties the output register.
module square_path_go_to_goal_controller
    import sqg2g_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [POS_W-1:0]  i_pose_x,
    input  logic signed [POS_W-1:0]  i_pose_y,
    input  logic signed [HEAD_W-1:0] i_heading,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [LIN_W-1:0]         o_linear_velocity,
    output logic signed [ANGV_W-1:0] o_angular_velocity,
    output logic [1:0]               o_corner_index,
    output logic                     o_corner_reached,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

`include "square_path_go_to_goal_controller_defines.svh"

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_LOAD = 12'b0000_0000_0010,
        S_RUN  = 12'b0000_0000_0100,
        S_MAGL = 12'b0000_0000_1000,
        S_MAGH = 12'b0000_0001_0000,
        S_MAGS = 12'b0000_0010_0000,
        S_CMP  = 12'b0000_0100_0000,
        S_LIN  = 12'b0000_1000_0000,
        S_LINW = 12'b0001_0000_0000,
        S_WRAP = 12'b0010_0000_0000,
        S_ANG  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    localparam logic signed [ERR_W-1:0] C_PI     = ERR_W'(PI_Q);
    localparam logic signed [ERR_W-1:0] C_TWO_PI = ERR_W'(TWO_PI_Q);
    localparam logic [ACC_W-1:0]        C_ROUND  = ACC_W'(1) << (MAG_SH - 1);
    localparam logic [MUL_A_W-1:0]      C_INV_K  = MUL_A_W'(INV_K_Q16);

    // Configuration registers
    logic signed [POS_W-1:0] r_origin_x;
    logic signed [POS_W-1:0] r_origin_y;
    logic [SIDE_W-1:0]       r_side;
    logic [SIDE_W-1:0]       r_tol;
    logic [GAIN_W-1:0]       r_lin_gain;
    logic [GAIN_W-1:0]       r_ang_gain;

    // Sequencer and working registers
    t_state                    r_state;
    t_state                    n_state;
    logic [1:0]                r_target;
    logic                      r_reached;
    logic signed [POS_W-1:0]   r_pose_x;
    logic signed [POS_W-1:0]   r_pose_y;
    logic signed [HEAD_W-1:0]  r_heading;
    logic [ACC_W-1:0]          r_acc;
    logic [MAG_W-1:0]          r_mag;
    logic [LIN_W-1:0]          r_lin;
    logic signed [ERR_W-1:0]   r_err;

    // Output register
    logic                      r_out_valid;
    logic [LIN_W-1:0]          r_o_lin;
    logic signed [ANGV_W-1:0]  r_o_ang;
    logic [1:0]                r_o_corner;
    logic                      r_o_reached;

    logic                      w_in_acc;
    logic                      w_out_load;
    logic                      w_advance;
    logic signed [DELTA_W-1:0] w_gx;
    logic signed [DELTA_W-1:0] w_gy;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic signed [DELTA_W-1:0] w_side_ext;
    t_cordic_ctl               w_cordic_ctl;
    t_cordic_sts               w_cordic_sts;
    logic [XU_W-1:0]           w_x;
    logic signed [ANG_W-1:0]   w_z;
    t_mul_req                  w_mul_req;
    logic signed [PROD_W-1:0]  w_prod;
    logic [ACC_W-1:0]          w_mag_sum;
    logic [LIN_W-1:0]          w_lin_sat;
    logic signed [ANGV_W-1:0]  w_ang_sat;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_advance   = (r_state == S_CMP) && !r_reached
                         && (r_mag <= {{(MAG_W-SIDE_W){1'b0}}, r_tol});

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_side     <= SIDE_W'(98304);
            r_tol      <= SIDE_W'(6554);
            r_lin_gain <= GAIN_W'(77);
            r_ang_gain <= GAIN_W'(768);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:    r_origin_x <= i_cfg_data[POS_W-1:0];
                CFG_ORIGIN_Y:    r_origin_y <= i_cfg_data[POS_W-1:0];
                CFG_SIDE_LENGTH: r_side     <= i_cfg_data[SIDE_W-1:0];
                CFG_ARRIVE_TOL:  r_tol      <= i_cfg_data[SIDE_W-1:0];
                CFG_LIN_GAIN:    r_lin_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_ANG_GAIN:    r_ang_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Corner minus pose for the current target
    assign w_side_ext = {{(DELTA_W-SIDE_W){1'b0}}, r_side};
    assign w_gx = DELTA_W'(r_origin_x) + ((r_target == 2'd0 || r_target == 2'd1) ?
                  w_side_ext : '0);
    assign w_gy = DELTA_W'(r_origin_y) + ((r_target == 2'd1 || r_target == 2'd2) ?
                  w_side_ext : '0);
    assign w_dx = w_gx - DELTA_W'(r_pose_x);
    assign w_dy = w_gy - DELTA_W'(r_pose_y);

    assign w_cordic_ctl.load = (r_state == S_LOAD);

    sqg2g_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cordic_ctl),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_sts   (w_cordic_sts),
        .o_x     (w_x),
        .o_z     (w_z)
    );

    // Multiplier requests per state
    always_comb begin
        w_mul_req.issue = 1'b0;
        w_mul_req.a     = C_INV_K;
        w_mul_req.b     = '0;
        unique case (r_state)
            S_MAGL: begin
                w_mul_req.issue = 1'b1;
                w_mul_req.b     = MUL_B_W'({1'b0, w_x[XL_W-1:0]});
            end
            S_MAGH: begin
                w_mul_req.issue = 1'b1;
                w_mul_req.b     = MUL_B_W'({1'b0, w_x[XU_W-1:XL_W]});
            end
            S_LIN: begin
                w_mul_req.issue = 1'b1;
                w_mul_req.a     = r_lin_gain;
                w_mul_req.b     = MUL_B_W'({1'b0, r_mag});
            end
            S_ANG: begin
                w_mul_req.issue = 1'b1;
                w_mul_req.a     = r_ang_gain;
                w_mul_req.b     = MUL_B_W'(r_err);
            end
            default: ;
        endcase
    end

    sqg2g_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    // Magnitude: add the high partial product to the rounded low one
    assign w_mag_sum = r_acc + ({{(ACC_W-PROD_W){1'b0}}, w_prod} << XL_W);

    // Saturate gain products after dropping the Q8.8 fraction
    assign w_lin_sat = (|w_prod[PROD_W-1:LIN_W+GAIN_SH]) ? '1
                       : w_prod[LIN_W+GAIN_SH-1:GAIN_SH];
    always_comb begin
        if ((&w_prod[PROD_W-1:ANGV_W+GAIN_SH-1]) || !(|w_prod[PROD_W-1:ANGV_W+GAIN_SH-1])) begin
            w_ang_sat = w_prod[ANGV_W+GAIN_SH-1:GAIN_SH];
        end else begin
            w_ang_sat = w_prod[PROD_W-1] ? {1'b1, {(ANGV_W-1){1'b0}}}
                        : {1'b0, {(ANGV_W-1){1'b1}}};
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_LOAD;
            S_LOAD: n_state = S_RUN;
            S_RUN:  if (w_cordic_sts.done) n_state = S_MAGL;
            S_MAGL: n_state = S_MAGH;
            S_MAGH: n_state = S_MAGS;
            S_MAGS: n_state = S_CMP;
            S_CMP:  n_state = w_advance ? S_LOAD : S_LIN;
            S_LIN:  n_state = S_LINW;
            S_LINW: n_state = S_WRAP;
            S_WRAP: if (r_err <= C_PI && r_err > -C_PI) n_state = S_ANG;
            S_ANG:  n_state = S_DONE;
            S_DONE: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= 2'd0;
            r_reached   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_reached <= 1'b0;
            end
            if (w_advance) begin
                r_target  <= r_target + 2'd1;
                r_reached <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pose_x  <= i_pose_x;
            r_pose_y  <= i_pose_y;
            r_heading <= i_heading;
        end
        if (r_state == S_MAGH) begin
            r_acc <= {{(ACC_W-PROD_W){1'b0}}, w_prod} + C_ROUND;
        end
        if (r_state == S_MAGS) begin
            r_mag <= w_mag_sum[MAG_SH+MAG_W-1:MAG_SH];
        end
        if (r_state == S_LIN) begin
            r_err <= ERR_W'(w_z) - ERR_W'(r_heading);
        end
        if (r_state == S_LINW) begin
            r_lin <= w_lin_sat;
        end
        // Wrap the heading error into (-pi, pi]
        if (r_state == S_WRAP) begin
            if (r_err > C_PI) begin
                r_err <= r_err - C_TWO_PI;
            end else if (r_err <= -C_PI) begin
                r_err <= r_err + C_TWO_PI;
            end
        end
        if (w_out_load) begin
            r_o_lin     <= r_lin;
            r_o_ang     <= w_ang_sat;
            r_o_corner  <= r_target;
            r_o_reached <= r_reached;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_linear_velocity  = r_o_lin;
    assign o_angular_velocity = r_o_ang;
    assign o_corner_index     = r_o_corner;
    assign o_corner_reached   = r_o_reached;

    `SQG2G_ASSERT_SAME(a_idle_cordic_quiet, i_clk, i_rst_n, o_in_ready, !w_cordic_sts.busy, "pose accepted while CORDIC busy")
    `SQG2G_ASSERT_NEXT(a_idle_target_hold, i_clk, i_rst_n, r_state == S_IDLE, r_target == $past(r_target), "target moved while idle")
    `SQG2G_ASSERT_SAME(a_err_wrapped, i_clk, i_rst_n, r_state == S_ANG, r_err <= C_PI && r_err > -C_PI, "heading error not wrapped")
    `SQG2G_ASSERT_NEXT(a_load_result, i_clk, i_rst_n, w_out_load, o_out_valid && o_corner_index == $past(r_target), "result not loaded with target")
    `SQG2G_ASSERT_NEXT(a_advance_once, i_clk, i_rst_n, w_advance, r_reached && r_state == S_LOAD, "advance did not restart pass")

endmodule

FILE: tb/square_path_go_to_goal_controller_tb.sv
module square_path_go_to_goal_controller_tb
    import sqg2g_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 60;
    localparam int MAX_REPORTS    = 40;
    localparam int PHASE_ITEMS    = 245;
    localparam int NUM_STEPS      = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;

    // Register defaults after reset
    localparam longint SIDE_RESET = 98304;
    localparam longint TOL_RESET  = 6554;
    localparam longint LGAIN_RESET = 77;
    localparam longint AGAIN_RESET = 768;

    // Field extremes
    localparam longint POS_HI  = 2**23 - 1;
    localparam longint POS_LO  = -(2**23);
    localparam longint HEAD_HI = 2**18 - 1;
    localparam longint HEAD_LO = -(2**18);
    localparam longint SIDE_HI = 2**23 - 1;
    localparam longint GAIN_HI = 2**16 - 1;
    localparam longint LIN_LIMIT = 2**24 - 1;
    localparam longint ANG_HI  = 2**23 - 1;
    localparam longint ANG_LO  = -(2**23);
    localparam longint MAG_ROUND = 2**23;

    // Indexes past the register list; the block drops these writes
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // atan(2^-i) in Q16, rounded
    localparam longint ATAN_STEP [24] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [LIN_W-1:0]         lin_vel;
        logic signed [ANGV_W-1:0] ang_vel;
        logic [1:0]               corner;
        logic                     reached;
    } t_goal_cmd;

    // Predicts one command per pose and matches arriving commands in order
    class t_goal_cmd_scoreboard;
        longint     org_x, org_y, side, tol, lin_gain, ang_gain;
        logic [1:0] corner;
        t_goal_cmd  pending[$];
        int unsigned n_poses, n_checked, n_advances, n_errors;

        function new();
            org_x    = 0;
            org_y    = 0;
            side     = SIDE_RESET;
            tol      = TOL_RESET;
            lin_gain = LGAIN_RESET;
            ang_gain = AGAIN_RESET;
            corner   = 2'd0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X:    org_x    = longint'($signed(data));
                CFG_ORIGIN_Y:    org_y    = longint'($signed(data));
                CFG_SIDE_LENGTH: side     = longint'(data[SIDE_W-1:0]);
                CFG_ARRIVE_TOL:  tol      = longint'(data[SIDE_W-1:0]);
                CFG_LIN_GAIN:    lin_gain = longint'(data[GAIN_W-1:0]);
                CFG_ANG_GAIN:    ang_gain = longint'(data[GAIN_W-1:0]);
                default: ;
            endcase
        endfunction

        function void corner_point(input logic [1:0] c, output longint gx, output longint gy);
            gx = org_x + ((c == 2'd0 || c == 2'd1) ? side : 0);
            gy = org_y + ((c == 2'd1 || c == 2'd2) ? side : 0);
        endfunction

        // Vectoring pass: range and bearing of (dx, dy)
        function void range_bearing(input longint dx, input longint dy,
                                    output longint mag, output longint bearing);
            longint x, y, z, nx;
            if (dx == 0 && dy == 0) begin
                mag = 0;
                bearing = 0;
                return;
            end
            x = dx * 256;
            y = dy * 256;
            z = 0;
            // fold the left half plane over by a half turn
            if (x < 0) begin
                z = (dy >= 0) ? PI_Q : -PI_Q;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < NUM_STEPS; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ATAN_STEP[i];
                end else begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ATAN_STEP[i];
                end
                x = nx;
            end
            if (x < 0)
                x = 0;
            mag = (x * INV_K_Q16 + MAG_ROUND) >>> 24;
            bearing = z;
        endfunction

        function void note_pose(input logic signed [POS_W-1:0] px_in,
                                input logic signed [POS_W-1:0] py_in,
                                input logic signed [HEAD_W-1:0] hd_in);
            longint    px, py, hd, gx, gy, d_goal, bear, err, lin, ang;
            t_goal_cmd cmd;
            px = px_in;
            py = py_in;
            hd = hd_in;
            corner_point(corner, gx, gy);
            range_bearing(gx - px, gy - py, d_goal, bear);
            cmd.reached = 1'b0;
            // advance once on arrival, then steer to the new corner
            if (d_goal <= tol) begin
                corner = corner + 2'd1;
                cmd.reached = 1'b1;
                n_advances++;
                corner_point(corner, gx, gy);
                range_bearing(gx - px, gy - py, d_goal, bear);
            end
            lin = (lin_gain * d_goal) >>> 8;
            if (lin > LIN_LIMIT)
                lin = LIN_LIMIT;
            // wrap heading error into (-pi, pi]
            err = bear - hd;
            while (err > PI_Q)
                err = err - TWO_PI_Q;
            while (err <= -PI_Q)
                err = err + TWO_PI_Q;
            ang = (ang_gain * err) >>> 8;
            if (ang > ANG_HI)
                ang = ANG_HI;
            if (ang < ANG_LO)
                ang = ANG_LO;
            cmd.lin_vel = LIN_W'(lin);
            cmd.ang_vel = ANGV_W'(ang);
            cmd.corner  = corner;
            pending = {pending, cmd};
            n_poses++;
        endfunction

        function void report_field(input string field, input longint want, input longint got);
            if (want != got) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_cmd(input logic [LIN_W-1:0] lin,
                                 input logic signed [ANGV_W-1:0] ang,
                                 input logic [1:0] c, input logic r);
            t_goal_cmd want;
            if (pending.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: command with no pose pending, expected none, got lin %0d",
                             $time, lin);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            report_field("linear_velocity", longint'(want.lin_vel), longint'(lin));
            report_field("angular_velocity", longint'(want.ang_vel), longint'(ang));
            report_field("corner_index", longint'(want.corner), longint'(c));
            report_field("corner_reached", longint'(want.reached), longint'(r));
        endfunction

        function void flush_check();
            if (pending.size() != 0) begin
                n_errors += pending.size();
                $display("%0t: %0d commands never arrived, expected 0 left, got %0d",
                         $time, pending.size(), pending.size());
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [POS_W-1:0]  i_pose_x;
    logic signed [POS_W-1:0]  i_pose_y;
    logic signed [HEAD_W-1:0] i_heading;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [LIN_W-1:0]         o_linear_velocity;
    logic signed [ANGV_W-1:0] o_angular_velocity;
    logic [1:0]               o_corner_index;
    logic                     o_corner_reached;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    t_goal_cmd_scoreboard sb = new();

    int tx_idle_pct;
    int rx_stall_pct;
    bit rx_hold_req;
    int rx_hold_left;
    int quiet_cycles;
    int n_cfg_writes;
    int n_settings;

    square_path_go_to_goal_controller u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_pose_x           (i_pose_x),
        .i_pose_y           (i_pose_y),
        .i_heading          (i_heading),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity),
        .o_corner_index     (o_corner_index),
        .o_corner_reached   (o_corner_reached),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Drive receiver ready: long hold-off on request, else random stalls
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = LONG_HOLD;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Check each command as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_cmd(o_linear_velocity, o_angular_velocity,
                         o_corner_index, o_corner_reached);
    end

    // Abort when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("square_path_go_to_goal_controller_tb: errors");
                $finish;
            end
        end
    end

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_HI)
            return POS_W'(POS_HI);
        if (v < POS_LO)
            return POS_W'(POS_LO);
        return POS_W'(v);
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SENDER:   begin tx_idle_pct = 64; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
            default:       begin tx_idle_pct = 31; rx_stall_pct = 31; end
        endcase
    endtask

    // Offer one pose request; valid stays up until it is taken
    task automatic send_pose(input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic signed [HEAD_W-1:0] hd);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pose_x   <= px;
        i_pose_y   <= py;
        i_heading  <= hd;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pose(px, py, hd);
    endtask

    // Drop valid and wait until every predicted command has come back
    task automatic drain_commands();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        n_cfg_writes++;
    endtask

    task automatic apply_config(input longint ox, input longint oy, input longint sd,
                                input longint tl, input longint lg, input longint ag);
        cfg_write(CFG_ORIGIN_X, CFG_DATA_W'(ox));
        cfg_write(CFG_ORIGIN_Y, CFG_DATA_W'(oy));
        cfg_write(CFG_SIDE_LENGTH, CFG_DATA_W'(sd));
        cfg_write(CFG_ARRIVE_TOL, CFG_DATA_W'(tl));
        cfg_write(CFG_LIN_GAIN, CFG_DATA_W'(lg));
        cfg_write(CFG_ANG_GAIN, CFG_DATA_W'(ag));
        // a stray index must leave every register alone
        cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7,
                  CFG_DATA_W'($urandom()));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Random poses, weighted toward the corner being driven to
    task automatic run_random(input int count, input int pause_at);
        longint gx, gy, ox, oy, span;
        int     pick;
        logic signed [HEAD_W-1:0] hd;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at)
                drain_commands();
            pick = $urandom_range(0, 99);
            sb.corner_point(sb.corner, gx, gy);
            if (pick < 45) begin
                span = sb.tol + sb.tol / 3 + 2;
                ox = longint'($urandom_range(0, 2 * span)) - span;
                oy = longint'($urandom_range(0, 2 * span)) - span;
            end else if (pick < 55) begin
                sb.corner_point(2'($urandom_range(0, 3)), gx, gy);
                ox = 0;
                oy = 0;
            end else if (pick < 80) begin
                span = sb.side + 64;
                gx = sb.org_x;
                gy = sb.org_y;
                ox = longint'($urandom_range(0, 2 * span)) - span / 2;
                oy = longint'($urandom_range(0, 2 * span)) - span / 2;
            end else begin
                gx = 0;
                gy = 0;
                ox = longint'($urandom_range(0, 2**24 - 1)) + POS_LO;
                oy = longint'($urandom_range(0, 2**24 - 1)) + POS_LO;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5)
                hd = HEAD_W'(PI_Q);
            else if (pick < 10)
                hd = HEAD_W'(-PI_Q);
            else if (pick < 85)
                hd = HEAD_W'(int'($urandom_range(0, 2 * PI_Q)) - PI_Q);
            else
                hd = HEAD_W'($urandom());
            send_pose(clamp_pos(gx + ox), clamp_pos(gy + oy), hd);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pose_x    <= '0;
        i_pose_y    <= '0;
        i_heading   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        rx_hold_req  = 1'b0;
        rx_hold_left = 0;
        quiet_cycles = 0;
        n_cfg_writes = 0;
        n_settings   = 0;
        set_idling(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners hit exactly and within tolerance, all quadrants, extremes
        send_pose(0, 0, 0);
        send_pose(SIDE_RESET, 0, PI_Q);
        send_pose(SIDE_RESET, SIDE_RESET, -PI_Q);
        send_pose(3000, SIDE_RESET - 3000, HEAD_LO);
        send_pose(-4000, 2000, HEAD_HI);
        send_pose(POS_HI, POS_LO, 0);
        send_pose(POS_LO, POS_HI, 100);
        send_pose(200000, 0, 0);
        send_pose(200000, 7, 1);
        send_pose(200000, -7, -1);
        send_pose(SIDE_RESET, -50000, 0);
        send_pose(SIDE_RESET, 50000, 0);
        send_pose(SIDE_RESET - TOL_RESET, 0, 0);
        send_pose(SIDE_RESET - TOL_RESET + 1, 0, 0);
        send_pose(SIDE_RESET - TOL_RESET - 1, 0, 0);
        drain_commands();

        // Directed: full gains to drive both commands into saturation
        apply_config(0, 0, SIDE_RESET, TOL_RESET, GAIN_HI, GAIN_HI);
        send_pose(POS_LO, 0, 100000);
        send_pose(POS_LO, 0, -100000);
        send_pose(POS_HI, POS_HI, HEAD_LO);
        send_pose(POS_LO, POS_LO, HEAD_HI);
        send_pose(0, 0, PI_Q);
        drain_commands();

        // Defaults written back, no idling
        apply_config(0, 0, SIDE_RESET, TOL_RESET, LGAIN_RESET, AGAIN_RESET);
        set_idling(IDLE_NONE);
        run_random(PHASE_ITEMS, -1);
        drain_commands();

        // Lowest register values, sender idling
        apply_config(POS_LO, POS_LO, 0, 0, 0, 0);
        set_idling(IDLE_SENDER);
        run_random(PHASE_ITEMS, -1);
        drain_commands();

        // Highest register values, receiver stalling
        apply_config(POS_HI, POS_HI, SIDE_HI, SIDE_HI, GAIN_HI, GAIN_HI);
        set_idling(IDLE_RECEIVER);
        run_random(PHASE_ITEMS, -1);
        drain_commands();

        // Mid-size random square, both sides idling
        begin
            longint sd;
            sd = $urandom_range(1000, 200000);
            apply_config(longint'($urandom_range(0, 2**21)) - 2**20,
                         longint'($urandom_range(0, 2**21)) - 2**20,
                         sd, $urandom_range(0, sd / 4),
                         $urandom_range(0, GAIN_HI), $urandom_range(0, GAIN_HI));
        end
        set_idling(IDLE_BOTH);
        run_random(PHASE_ITEMS, -1);
        drain_commands();

        // Tiny square; receiver holds off long so the input backs up
        apply_config(longint'($urandom_range(0, 2**16)) - 2**15, -3000, 300, 50, 256, 256);
        set_idling(IDLE_NONE);
        rx_hold_req = 1'b1;
        run_random(PHASE_ITEMS, -1);
        drain_commands();

        // Full-range random registers; sender pauses midway until all commands return
        apply_config($urandom_range(0, 2**24 - 1), $urandom_range(0, 2**24 - 1),
                     $urandom_range(0, SIDE_HI), $urandom_range(0, SIDE_HI),
                     $urandom_range(0, GAIN_HI), $urandom_range(0, GAIN_HI));
        set_idling(IDLE_SENDER);
        run_random(PHASE_ITEMS, PHASE_ITEMS / 2);
        drain_commands();

        // Default square moved to negative origin
        apply_config(-250000, -120000, SIDE_RESET, TOL_RESET, LGAIN_RESET, AGAIN_RESET);
        set_idling(IDLE_RECEIVER);
        run_random(PHASE_ITEMS, -1);
        drain_commands();

        // Random square, random gains
        begin
            longint sd;
            sd = $urandom_range(64, 2**20);
            apply_config(longint'($urandom_range(0, 2**23)) - 2**22,
                         longint'($urandom_range(0, 2**23)) - 2**22,
                         sd, $urandom_range(0, sd / 2),
                         $urandom_range(0, GAIN_HI), $urandom_range(0, GAIN_HI));
        end
        set_idling(IDLE_BOTH);
        run_random(PHASE_ITEMS, -1);
        drain_commands();

        // Let any stray command show up before closing
        repeat (END_CYCLES) @(posedge i_clk);
        sb.flush_check();
        $display("covered %0d poses over %0d register settings, %0d corner advances",
                 sb.n_poses, n_settings, sb.n_advances);
        $display("checked %0d commands, %0d register writes including stray indexes",
                 sb.n_checked, n_cfg_writes);
        if (sb.n_errors == 0)
            $display("square_path_go_to_goal_controller_tb: clean");
        else
            $display("square_path_go_to_goal_controller_tb: errors");
        $finish;
    end

endmodule
